// File: sv/acdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acdr_pkg
// Shared types and constants of the box collision direction resolve unit.
// ----------------------------------------------------------------------------
package acdr_pkg;

    // rectangle word: four 16-bit lanes
    localparam int LANE_BITS  = 16;
    localparam int LANE_COUNT = 4;
    localparam int RECT_BITS  = LANE_BITS * LANE_COUNT;
    localparam int FORCE_BITS = 16;
    localparam int DIR_BITS   = 4;

    // lane positions inside a rectangle word
    localparam int LANE_LX = 0;
    localparam int LANE_LY = 1;
    localparam int LANE_RX = 2;
    localparam int LANE_RY = 3;

    typedef logic [DIR_BITS-1:0] dir_t;

    // hit direction mask bits
    localparam dir_t HIT_NONE  = 4'b0000;
    localparam dir_t HIT_TOP   = 4'b0001;
    localparam dir_t HIT_BOT   = 4'b0010;
    localparam dir_t HIT_LEFT  = 4'b0100;
    localparam dir_t HIT_RIGHT = 4'b1000;

endpackage : acdr_pkg
`default_nettype wire

// File: sv/aabb_collision_direction_resolve_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_collision_direction_resolve_unit
// Finds the side from which a moving box newly hits an obstacle box and
// pushes the mover out when its force does not exceed the obstacle drag.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  input   | in_valid/in_ready  | four rectangles, mover_force, obstacle_drag
//  output  | out_valid/out_ready| hit_direction, was_resolved, split_needed,
//          |                    | mover_after
//
//  one transfer in and one out per cycle sustained while out_ready holds;
//  a result passes from the input register into the result register, from
//  which it is offered; the path between the two is compares, adds and
//  lane saturation
//  reset clears both valid flags only; payload registers are not reset
//  a stalled result holds in the result register while the input register
//  still takes one more item; input ready drops only when both are full
// ----------------------------------------------------------------------------
module aabb_collision_direction_resolve_unit #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [acdr_pkg::RECT_BITS-1:0]  mover_now,
    input  wire logic [acdr_pkg::RECT_BITS-1:0]  mover_before,
    input  wire logic [acdr_pkg::RECT_BITS-1:0]  obstacle_now,
    input  wire logic [acdr_pkg::RECT_BITS-1:0]  obstacle_before,
    input  wire logic [acdr_pkg::FORCE_BITS-1:0] mover_force,
    input  wire logic [acdr_pkg::FORCE_BITS-1:0] obstacle_drag,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [acdr_pkg::DIR_BITS-1:0]        hit_direction,
    output logic                                 was_resolved,
    output logic                                 split_needed,
    output logic [acdr_pkg::RECT_BITS-1:0]       mover_after
);

    import acdr_pkg::*;

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int SUM_BITS  = COORD_BITS + 2;
    localparam logic signed [SUM_BITS-1:0] SAT_HI =
        SUM_BITS'((1 << (COORD_BITS - 1)) - 1);
    localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;

    // pick the axis with the smaller penetration, both on a tie
    function automatic dir_t pick(diff_t h, diff_t v, dir_t vdir, dir_t hdir);
        dir_t res;
        priority if (v < h)
            res = vdir;
        else if (h < v)
            res = hdir;
        else
            res = vdir | hdir;
        return res;
    endfunction

    // clamp a widened coordinate to the signed coordinate range
    function automatic coord_t sat(sum_t v);
        coord_t res;
        priority if (v > SAT_HI)
            res = SAT_HI[COORD_BITS-1:0];
        else if (v < SAT_LO)
            res = SAT_LO[COORD_BITS-1:0];
        else
            res = v[COORD_BITS-1:0];
        return res;
    endfunction

    // a + b - c widened so that nothing wraps
    function automatic coord_t add_sub_sat(coord_t a, coord_t b, coord_t c);
        sum_t s;
        s = SUM_BITS'(a) + SUM_BITS'(b) - SUM_BITS'(c);
        return sat(s);
    endfunction

    // input register
    logic                  in_valid_reg;
    logic [RECT_BITS-1:0]  mover_now_reg;
    logic [RECT_BITS-1:0]  mover_before_reg;
    logic [RECT_BITS-1:0]  obstacle_now_reg;
    logic [RECT_BITS-1:0]  obstacle_before_reg;
    logic [FORCE_BITS-1:0] mover_force_reg;
    logic [FORCE_BITS-1:0] obstacle_drag_reg;

    // result register
    logic                 out_valid_reg;
    dir_t                 hit_direction_reg;
    logic                 was_resolved_reg;
    logic                 split_needed_reg;
    logic [RECT_BITS-1:0] mover_after_reg;

    dir_t                 hit_direction_next;
    logic                 was_resolved_next;
    logic                 split_needed_next;
    logic [RECT_BITS-1:0] mover_after_next;

    logic in_valid_reg_next;
    logic out_valid_reg_next;
    logic out_load;

    coord_t m [LANE_COUNT];
    coord_t p [LANE_COUNT];
    coord_t o [LANE_COUNT];
    coord_t q [LANE_COUNT];
    coord_t r [LANE_COUNT];

    logic  cur_overlap;
    logic  prev_overlap;
    diff_t pen_left;
    diff_t pen_right;
    diff_t pen_top;
    diff_t pen_bot;

    // handshake control
    always_comb
    begin
        out_load           = in_valid_reg && (!out_valid_reg || out_ready);
        in_ready           = !in_valid_reg || out_load;
        in_valid_reg_next  = in_ready ? in_valid : 1'b1;
        out_valid_reg_next = out_load ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_reg_next;
            out_valid_reg <= out_valid_reg_next;
        end
    end

    // capture the input transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mover_now_reg       <= mover_now;
            mover_before_reg    <= mover_before;
            obstacle_now_reg    <= obstacle_now;
            obstacle_before_reg <= obstacle_before;
            mover_force_reg     <= mover_force;
            obstacle_drag_reg   <= obstacle_drag;
        end
    end

    // unpack lanes, upper lane bits ignored
    always_comb
    begin
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            m[i] = $signed(mover_now_reg[i*LANE_BITS +: COORD_BITS]);
            p[i] = $signed(mover_before_reg[i*LANE_BITS +: COORD_BITS]);
            o[i] = $signed(obstacle_now_reg[i*LANE_BITS +: COORD_BITS]);
            q[i] = $signed(obstacle_before_reg[i*LANE_BITS +: COORD_BITS]);
        end
    end

    // overlap now and before, penetration depths
    always_comb
    begin
        cur_overlap  = !(m[LANE_RX] <= o[LANE_LX] || o[LANE_RX] <= m[LANE_LX] ||
                         m[LANE_LY] <= o[LANE_RY] || o[LANE_LY] <= m[LANE_RY]);
        prev_overlap = !(p[LANE_RX] <= q[LANE_LX] || q[LANE_RX] <= p[LANE_LX] ||
                         p[LANE_LY] <= q[LANE_RY] || q[LANE_LY] <= p[LANE_RY]);
        pen_left  = DIFF_BITS'(o[LANE_RX]) - DIFF_BITS'(m[LANE_LX]);
        pen_right = DIFF_BITS'(m[LANE_RX]) - DIFF_BITS'(o[LANE_LX]);
        pen_top   = DIFF_BITS'(m[LANE_LY]) - DIFF_BITS'(o[LANE_RY]);
        pen_bot   = DIFF_BITS'(o[LANE_LY]) - DIFF_BITS'(m[LANE_RY]);
    end

    // hit side: orthogonal approaches first, then diagonal
    always_comb
    begin
        priority if (!cur_overlap || prev_overlap)
            hit_direction_next = HIT_NONE;
        else if (o[LANE_LX] < p[LANE_RX] && p[LANE_LX] < o[LANE_RX] &&
                 p[LANE_LY] <= o[LANE_RY])
            hit_direction_next = HIT_TOP;
        else if (o[LANE_LX] < p[LANE_RX] && p[LANE_LX] < o[LANE_RX] &&
                 o[LANE_LY] <= p[LANE_RY])
            hit_direction_next = HIT_BOT;
        else if (o[LANE_RY] < p[LANE_LY] && p[LANE_RY] < o[LANE_LY] &&
                 p[LANE_RX] <= o[LANE_LX])
            hit_direction_next = HIT_LEFT;
        else if (o[LANE_RY] < p[LANE_LY] && p[LANE_RY] < o[LANE_LY] &&
                 o[LANE_RX] <= p[LANE_LX])
            hit_direction_next = HIT_RIGHT;
        else if (o[LANE_LX] <= p[LANE_LX] && p[LANE_LY] <= o[LANE_LY])
            hit_direction_next = pick(pen_left, pen_top, HIT_TOP, HIT_LEFT);
        else if (p[LANE_RX] <= o[LANE_RX] && p[LANE_LY] <= o[LANE_LY])
            hit_direction_next = pick(pen_right, pen_top, HIT_TOP, HIT_RIGHT);
        else if (o[LANE_LX] <= p[LANE_LX] && o[LANE_RY] <= p[LANE_RY])
            hit_direction_next = pick(pen_left, pen_bot, HIT_BOT, HIT_LEFT);
        else if (p[LANE_RX] <= o[LANE_RX] && o[LANE_RY] <= p[LANE_RY])
            hit_direction_next = pick(pen_right, pen_bot, HIT_BOT, HIT_RIGHT);
        else
            hit_direction_next = HIT_NONE;
    end

    // push out along the hit axes when force does not exceed drag
    always_comb
    begin
        logic hit;
        logic pushable;
        hit               = (hit_direction_next != HIT_NONE);
        pushable          = (mover_force_reg <= obstacle_drag_reg);
        was_resolved_next = hit && pushable;
        split_needed_next = hit && !pushable;

        for (int i = 0; i < LANE_COUNT; i++)
            r[i] = m[i];

        if (was_resolved_next)
        begin
            // moved edge lands on the obstacle edge, the other shifts with it
            if ((hit_direction_next & HIT_LEFT) != HIT_NONE)
            begin
                r[LANE_LX] = o[LANE_RX];
                r[LANE_RX] = add_sub_sat(m[LANE_RX], o[LANE_RX], m[LANE_LX]);
            end
            if ((hit_direction_next & HIT_RIGHT) != HIT_NONE)
            begin
                r[LANE_LX] = add_sub_sat(m[LANE_LX], o[LANE_LX], m[LANE_RX]);
                r[LANE_RX] = o[LANE_LX];
            end
            if ((hit_direction_next & HIT_TOP) != HIT_NONE)
            begin
                r[LANE_LY] = o[LANE_RY];
                r[LANE_RY] = add_sub_sat(m[LANE_RY], o[LANE_RY], m[LANE_LY]);
            end
            if ((hit_direction_next & HIT_BOT) != HIT_NONE)
            begin
                r[LANE_LY] = add_sub_sat(m[LANE_LY], o[LANE_LY], m[LANE_RY]);
                r[LANE_RY] = o[LANE_LY];
            end
        end

        // repack, upper lane bits zero
        for (int i = 0; i < LANE_COUNT; i++)
            mover_after_next[i*LANE_BITS +: LANE_BITS] =
                LANE_BITS'($unsigned(r[i]));
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            hit_direction_reg <= hit_direction_next;
            was_resolved_reg  <= was_resolved_next;
            split_needed_reg  <= split_needed_next;
            mover_after_reg   <= mover_after_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit_direction = hit_direction_reg;
    assign was_resolved  = was_resolved_reg;
    assign split_needed  = split_needed_reg;
    assign mover_after   = mover_after_reg;

endmodule : aabb_collision_direction_resolve_unit
`default_nettype wire

// File: sv/acdr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acdr_checker
// Port level checks on the results of the collision direction resolve unit.
// ----------------------------------------------------------------------------
module acdr_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [acdr_pkg::DIR_BITS-1:0]   hit_direction,
    input wire logic                            was_resolved,
    input wire logic                            split_needed,
    input wire logic [acdr_pkg::RECT_BITS-1:0]  mover_after
);

    import acdr_pkg::*;

    // a hit is either pushed out or flagged, never both
    a_resolve_split_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> !(was_resolved && split_needed))
    else $error("resolved and split both set");

    // no hit means no push and no split flag
    a_no_hit_no_action: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && hit_direction == HIT_NONE) |-> (!was_resolved && !split_needed))
    else $error("action reported without a hit");

    // a hit always leads to a push or a split flag
    a_hit_has_action: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && hit_direction != HIT_NONE) |-> (was_resolved || split_needed))
    else $error("hit reported without action");

    // opposite sides never reported together
    a_no_opposite_sides: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> ((hit_direction & (HIT_TOP | HIT_BOT)) != (HIT_TOP | HIT_BOT) &&
                       (hit_direction & (HIT_LEFT | HIT_RIGHT)) != (HIT_LEFT | HIT_RIGHT)))
    else $error("opposite hit sides reported");

    // stalled result holds
    a_stall_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(hit_direction) &&
            $stable(was_resolved) && $stable(split_needed) && $stable(mover_after)))
    else $error("stalled result changed");

endmodule : acdr_checker

bind aabb_collision_direction_resolve_unit acdr_checker u_acdr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit_direction (hit_direction),
    .was_resolved  (was_resolved),
    .split_needed  (split_needed),
    .mover_after   (mover_after)
);
`default_nettype wire
